// ===== src/shabh_pkg.sv =====
// Shared types, constants and round functions of the bit-stream SHA-256 hasher.
package shabh_pkg;

	typedef enum logic [1:0] {
		ACT_ADD     = 2'd0,
		ACT_FINAL   = 2'd1,
		ACT_RESTART = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_AFTER_FINAL = 2'd1,
		STAT_TOO_LONG    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
		logic [3:0] valid_bits;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		act_t       op;
		logic [7:0] data;
		logic [3:0] nbits;
	} cmd_t;

	typedef logic [7:0][31:0]  hash_t;
	typedef logic [15:0][31:0] block_t;

	localparam hash_t IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

endpackage

// ===== src/shabh_front.sv =====
// Front end: accepts items, decodes and masks them, and queues commands for the back end.
module shabh_front
	import shabh_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	output logic  cmd_valid,
	input  logic  cmd_pop,
	output cmd_t  cmd
);

	cmd_t       queue_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       store;
	logic [3:0] nsat;

	always_comb begin
		nsat = (item.valid_bits > 4'd8) ? 4'd8 : item.valid_bits;
		dec.op = act_t'(item.action);
		dec.nbits = nsat;
		dec.data = item.data_byte & ~(8'hFF >> nsat);
	end

	assign full = (cnt_q == 2'd2);
	assign store = push && !full && (dec.op == ACT_ADD || dec.op == ACT_FINAL
		|| dec.op == ACT_RESTART);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = queue_q[rp_q];

	always_ff @(posedge clk) begin
		if (store) begin
			queue_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (store) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, store} - {1'b0, cmd_pop};
		end
	end

endmodule

// ===== src/shabh_comp.sv =====
// Compression unit: message schedule and one SHA-256 round per cycle.
module shabh_comp
	import shabh_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  block_t blk,
	input  hash_t  cv,
	output logic   done,
	output hash_t  vout
);

	logic [31:0] w_q [16];
	hash_t       v_q;
	logic [5:0]  t_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] wnew;

	always_comb begin
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + big_sig1(v_q[4]) + ch + K[t_q] + w_q[0];
		t2 = big_sig0(v_q[0]) + maj;
		wnew = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk[i];
			end
			v_q <= cv;
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wnew;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= 6'd0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				t_q <= 6'd0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				t_q <= t_q + 6'd1;
				if (t_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign vout = v_q;

endmodule

// ===== src/shabh_back.sv =====
// Back end: bit packing, padding, block control, chaining value and result queue.
module shabh_back
	import shabh_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_pop,
	input  cmd_t    cmd,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	state_t      state_q;
	state_t      state_d;
	hash_t       cv_q;
	logic [31:0] buf_q [16];
	logic [63:0] count_q;
	logic [2:0]  off_q;
	logic [7:0]  cur_q;
	logic [5:0]  pos_q;
	logic        done_q;
	status_t     err_q;
	logic        fin_q;
	logic        second_q;
	logic [6:0]  valid_q;
	logic        len_q;
	logic [2:0]  idx_q;

	result_t     ofifo_q [8];
	logic [2:0]  owp_q;
	logic [2:0]  orp_q;
	logic [3:0]  ocnt_q;
	logic        ofull;
	logic        res_push;
	result_t     res_d;

	logic        comp_start;
	logic        comp_done;
	hash_t       comp_v;
	block_t      blk;

	logic [64:0] sum65;
	logic        ovf;
	status_t     add_status;
	logic        add_go;
	logic [3:0]  bsum;
	logic [7:0]  shifted;
	logic [7:0]  spill;
	logic        wrap;
	logic [6:0]  p1;
	logic        wr_en;
	logic [7:0]  wr_byte;
	logic [4:0]  lane_sh;

	shabh_comp u_comp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (comp_start),
		.blk    (blk),
		.cv     (cv_q),
		.done   (comp_done),
		.vout   (comp_v)
	);

	always_comb begin
		sum65 = {1'b0, count_q} + 65'(cmd.nbits);
		ovf = sum65[64];
		add_go = (err_q == STAT_OK) && !done_q && (cmd.nbits != 4'd0) && !ovf;
		if (err_q != STAT_OK) begin
			add_status = err_q;
		end else if (done_q) begin
			add_status = STAT_AFTER_FINAL;
		end else if (cmd.nbits == 4'd0) begin
			add_status = STAT_OK;
		end else if (ovf) begin
			add_status = STAT_TOO_LONG;
		end else begin
			add_status = STAT_OK;
		end
		bsum = {1'b0, off_q} + cmd.nbits;
		shifted = cmd.data >> off_q;
		spill = 8'({8'd0, cmd.data} << (4'd8 - {1'b0, off_q}));
		wrap = add_go && bsum[3] && (pos_q == 6'd63);
		p1 = {1'b0, pos_q} + 7'd1;
		lane_sh = {~pos_q[1:0], 3'b000};
	end

	always_comb begin
		for (int i = 0; i < 64; i++) begin
			if (7'(i) < valid_q) begin
				blk[i / 4][8 * (3 - i % 4) +: 8] = buf_q[i / 4][8 * (3 - i % 4) +: 8];
			end else begin
				blk[i / 4][8 * (3 - i % 4) +: 8] = 8'd0;
			end
		end
		if (len_q) begin
			blk[14] = count_q[63:32];
			blk[15] = count_q[31:0];
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		res_push = 1'b0;
		res_d.status = STAT_OK;
		res_d.digest_word = 32'd0;
		res_d.word_index = 3'd0;
		res_d.last_of_run = 1'b1;
		comp_start = 1'b0;
		wr_en = 1'b0;
		wr_byte = cur_q | shifted;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && !ofull) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						ACT_RESTART: begin
							res_push = 1'b1;
						end
						ACT_ADD: begin
							res_push = 1'b1;
							res_d.status = add_status;
							wr_en = add_go && bsum[3];
							if (wrap) begin
								state_d = ST_START;
							end
						end
						ACT_FINAL: begin
							if (err_q != STAT_OK) begin
								res_push = 1'b1;
								res_d.status = err_q;
							end else if (done_q) begin
								state_d = ST_EMIT;
							end else begin
								wr_en = 1'b1;
								wr_byte = cur_q | (8'h80 >> off_q);
								state_d = ST_START;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_START: begin
				comp_start = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (comp_done) begin
					if (second_q) begin
						state_d = ST_START;
					end else if (fin_q) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (!ofull) begin
					res_push = 1'b1;
					res_d.digest_word = cv_q[idx_q];
					res_d.word_index = idx_q;
					res_d.last_of_run = (idx_q == 3'd7);
					if (idx_q == 3'd7) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[pos_q[5:2]][lane_sh +: 8] <= wr_byte;
		end
		if (res_push) begin
			ofifo_q[owp_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cv_q <= IV;
			count_q <= 64'd0;
			off_q <= 3'd0;
			cur_q <= 8'd0;
			pos_q <= 6'd0;
			done_q <= 1'b0;
			err_q <= STAT_OK;
			fin_q <= 1'b0;
			second_q <= 1'b0;
			valid_q <= 7'd0;
			len_q <= 1'b0;
			idx_q <= 3'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && cmd_pop) begin
				case (cmd.op)
					ACT_RESTART: begin
						cv_q <= IV;
						count_q <= 64'd0;
						off_q <= 3'd0;
						cur_q <= 8'd0;
						pos_q <= 6'd0;
						done_q <= 1'b0;
						err_q <= STAT_OK;
					end
					ACT_ADD: begin
						err_q <= add_status;
						if (add_go) begin
							count_q <= sum65[63:0];
							off_q <= bsum[2:0];
							if (bsum[3]) begin
								cur_q <= spill;
								pos_q <= pos_q + 6'd1;
							end else begin
								cur_q <= cur_q | shifted;
							end
						end
						if (wrap) begin
							valid_q <= 7'd64;
							len_q <= 1'b0;
							second_q <= 1'b0;
							fin_q <= 1'b0;
						end
					end
					ACT_FINAL: begin
						if (err_q == STAT_OK && !done_q) begin
							valid_q <= p1;
							fin_q <= 1'b1;
							if (p1 > 7'd56) begin
								len_q <= 1'b0;
								second_q <= 1'b1;
							end else begin
								len_q <= 1'b1;
								second_q <= 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_WAIT && comp_done) begin
				for (int i = 0; i < 8; i++) begin
					cv_q[i] <= cv_q[i] + comp_v[i];
				end
				if (second_q) begin
					second_q <= 1'b0;
					valid_q <= 7'd0;
					len_q <= 1'b1;
				end else if (fin_q) begin
					fin_q <= 1'b0;
					done_q <= 1'b1;
					off_q <= 3'd0;
					cur_q <= 8'd0;
					pos_q <= 6'd0;
				end
			end
			if (state_q == ST_EMIT && res_push) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	assign ofull = (ocnt_q == 4'd8);
	assign empty = (ocnt_q == 4'd0);
	assign result = ofifo_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= 3'd0;
			orp_q <= 3'd0;
			ocnt_q <= 4'd0;
		end else begin
			if (res_push) begin
				owp_q <= owp_q + 3'd1;
			end
			if (pop && !empty) begin
				orp_q <= orp_q + 3'd1;
			end
			ocnt_q <= ocnt_q + {3'd0, res_push} - {3'd0, pop && !empty};
		end
	end

endmodule

// ===== src/sha256_bit_stream_hasher.sv =====
// Top level of the bit-stream SHA-256 hasher: front end, command queue and back end.
//
//   channel   direction   transfer when        payload
//   item      in          push && !full        item_t (action, data_byte, valid_bits)
//   result    out         pop && !empty        result_t (status, digest_word, word_index,
//                                                        last_of_run)
//
// An add that completes a 64-byte block starts the one-round-per-cycle
// compression unit; no command is taken until it is done. A first finalize runs
// one or two compressions, a repeated one none, and then the digest is emitted.
// Reset is asynchronous and loads the initial hash values. Either side may stall
// freely; a two-entry command queue and an eight-entry result queue decouple them.
module sha256_bit_stream_hasher
	import shabh_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	shabh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	shabh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== bench/digest_checker.sv =====
// Checker that predicts the status and digest results of the hasher and compares every result transfer.
module digest_checker
	import shabh_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  logic    full,
	input  item_t   item,
	input  logic    empty,
	input  logic    pop,
	input  result_t result,
	output int      errors,
	output int      pending
);

	logic [31:0] chain [8];
	logic [7:0]  blk [64];
	logic [63:0] bit_count;
	logic [2:0]  bit_off;
	logic [6:0]  byte_pos;
	logic        done;
	status_t     sticky;
	result_t     expected_results [$];

	function automatic logic [31:0] rotr(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void clear_state();
		for (int i = 0; i < 8; i++) chain[i] = IV[i];
		for (int i = 0; i < 64; i++) blk[i] = 8'h00;
		bit_count = '0;
		bit_off = '0;
		byte_pos = '0;
		done = 1'b0;
		sticky = STAT_OK;
	endfunction

	function automatic void compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
				+ (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
		for (int i = 0; i < 8; i++) v[i] = chain[i];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[t] + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
		byte_pos = '0;
	endfunction

	function automatic void append(logic [7:0] data, int n);
		logic [7:0]  masked;
		logic [15:0] spread;
		int          pos;
		masked = data & (8'hFF << (8 - n));
		spread = {masked, 8'h00} >> bit_off;
		pos = byte_pos;
		if (bit_off == 0) blk[pos] = 8'h00;
		blk[pos] = blk[pos] | spread[15:8];
		if (bit_off + n >= 8) begin
			pos++;
			if (pos == 64) begin
				compress();
				pos = 0;
			end
			blk[pos] = spread[7:0];
		end
		byte_pos = pos;
		bit_off = bit_off + n;
	endfunction

	function automatic void finish();
		int pos;
		logic [63:0] cnt;
		pos = byte_pos;
		cnt = bit_count;
		if (bit_off == 0) blk[pos] = 8'h80;
		else blk[pos] = blk[pos] | (8'h80 >> bit_off);
		pos++;
		if (pos > 56) begin
			for (int i = pos; i < 64; i++) blk[i] = 8'h00;
			compress();
			for (int i = 0; i < 56; i++) blk[i] = 8'h00;
		end else begin
			for (int i = pos; i < 56; i++) blk[i] = 8'h00;
		end
		for (int i = 63; i > 55; i--) begin
			blk[i] = cnt[7:0];
			cnt = cnt >> 8;
		end
		compress();
		done = 1'b1;
		bit_off = '0;
		for (int i = 0; i < 64; i++) blk[i] = 8'h00;
	endfunction

	function automatic void expect_status(status_t s);
		result_t r;
		r = '0;
		r.status = s;
		r.last_of_run = 1'b1;
		expected_results.push_back(r);
	endfunction

	function automatic void predict(item_t it);
		int      n;
		result_t r;
		case (it.action)
			ACT_ADD: begin
				n = (it.valid_bits > 8) ? 8 : it.valid_bits;
				if (sticky != STAT_OK) begin
					expect_status(sticky);
				end else if (done) begin
					sticky = STAT_AFTER_FINAL;
					expect_status(sticky);
				end else if (n == 0) begin
					expect_status(STAT_OK);
				end else if (bit_count + 64'(n) < bit_count) begin
					sticky = STAT_TOO_LONG;
					expect_status(sticky);
				end else begin
					bit_count = bit_count + 64'(n);
					append(it.data_byte, n);
					expect_status(STAT_OK);
				end
			end
			ACT_FINAL: begin
				if (sticky != STAT_OK) begin
					expect_status(sticky);
				end else begin
					if (!done) finish();
					for (int i = 0; i < 8; i++) begin
						r.status = STAT_OK;
						r.digest_word = chain[i];
						r.word_index = 3'(i);
						r.last_of_run = (i == 7);
						expected_results.push_back(r);
					end
				end
			end
			ACT_RESTART: begin
				clear_state();
				expect_status(STAT_OK);
			end
			default: ;
		endcase
	endfunction

	initial begin
		errors = 0;
		clear_state();
	end

	assign pending = expected_results.size();

	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			if (push && !full) predict(item);
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no result expected");
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (result.status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, result.status);
						errors++;
					end
					if (result.digest_word !== e.digest_word) begin
						$error("digest_word expected %h actual %h", e.digest_word,
							result.digest_word);
						errors++;
					end
					if (result.word_index !== e.word_index) begin
						$error("word_index expected %0d actual %0d", e.word_index,
							result.word_index);
						errors++;
					end
					if (result.last_of_run !== e.last_of_run) begin
						$error("last_of_run expected %0d actual %0d", e.last_of_run,
							result.last_of_run);
						errors++;
					end
				end
			end
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the hasher bench: clock, reset, item and result traffic, watchdog and verdict.
module testbench;
	import shabh_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	item_t   item = '0;
	logic    empty;
	logic    pop = 1'b0;
	result_t result;
	int      errors;
	int      pending;
	int      sender_idle = 0;
	int      recv_stall = 0;
	int      sent = 0;
	int      quiet = 0;
	bit      hold_req = 1'b0;
	bit      hold_done = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sha256_bit_stream_hasher dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	digest_checker u_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .errors(errors), .pending(pending)
	);

	task automatic send(logic [1:0] act, logic [7:0] data, logic [3:0] nbits);
		while ($urandom_range(99) < sender_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= '{action: act, data_byte: data, valid_bits: nbits};
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
	endtask

	task automatic random_message();
		int len;
		logic [3:0] nb;
		len = ($urandom_range(99) < 25) ? $urandom_range(70, 50) : $urandom_range(10);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(19))
				0: nb = 4'(ACT_ADD);
				1: nb = 4'($urandom_range(15, 9));
				2, 3, 4, 5: nb = 4'($urandom_range(8, 1));
				default: nb = 4'd8;
			endcase
			if ($urandom_range(99) < 4) send(2'd3, 8'($urandom_range(255)), 4'($urandom));
			send(ACT_ADD, 8'($urandom_range(255)), nb);
		end
		send(ACT_FINAL, 8'($urandom_range(255)), 4'($urandom));
		if ($urandom_range(99) < 20) send(ACT_FINAL, 8'h00, 4'd0);
		if ($urandom_range(99) < 10) begin
			send(ACT_ADD, 8'($urandom_range(255)), 4'd8);
			send(ACT_FINAL, 8'h00, 4'd0);
		end
		send(ACT_RESTART, 8'($urandom_range(255)), 4'($urandom));
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				pop <= 1'b0;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
			end
			pop <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= 5000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(ACT_FINAL, 8'h00, 4'd0);
		send(ACT_FINAL, 8'hFF, 4'd15);
		send(ACT_ADD, 8'hFF, 4'd8);
		send(ACT_ADD, 8'h00, 4'd1);
		send(ACT_FINAL, 8'h00, 4'd0);
		send(ACT_RESTART, 8'h00, 4'd0);
		send(ACT_ADD, 8'h61, 4'd8);
		send(ACT_ADD, 8'h62, 4'd8);
		send(ACT_ADD, 8'h63, 4'd8);
		send(ACT_FINAL, 8'h00, 4'd0);
		send(ACT_RESTART, 8'hFF, 4'd15);
		send(ACT_ADD, 8'hFF, 4'd1);
		send(ACT_ADD, 8'h00, 4'd0);
		send(ACT_ADD, 8'hA5, 4'd15);
		send(ACT_ADD, 8'h5A, 4'd9);
		send(ACT_ADD, 8'h3C, 4'd3);
		send(2'd3, 8'hFF, 4'd8);
		send(ACT_ADD, 8'hFF, 4'd7);
		send(ACT_FINAL, 8'h00, 4'd0);
		send(ACT_RESTART, 8'h00, 4'd0);
		while (sent < 220) begin
			case ((sent - 20) / 55)
				0: begin sender_idle = 0; recv_stall = 0; end
				1: begin sender_idle = 76; recv_stall = 0; end
				2: begin sender_idle = 0; recv_stall = 76; end
				default: begin sender_idle = 7; recv_stall = 7; end
			endcase
			if (sent >= 40) hold_req = 1'b1;
			if (sent >= 140 && sent < 160) begin
				push <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			random_message();
		end
		push <= 1'b0;
		recv_stall = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
